/* src/aabb_ray_slab_test_assert.svh */
`ifndef AABB_RAY_SLAB_TEST_ASSERT_SVH
`define AABB_RAY_SLAB_TEST_ASSERT_SVH

// Checked at every clock edge outside reset.
`define AABB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define AABB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/aabb_pkg.sv */
package aabb_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int FIELD_W    = 32;
  localparam int NUM_FIELDS = 12;
  localparam int AXES       = 3;
  localparam int LANES      = 2 * AXES;

  typedef enum logic [1:0] {
    KIND_SEGMENT = 2'd0,
    KIND_LINE    = 2'd1,
    KIND_RAY     = 2'd2
  } query_kind_t;

  typedef struct packed {
    logic [AXES-1:0] dz;
    logic            ok;
  } aabb_flags_t;

endpackage

/* src/aabb_prep.sv */
module aabb_prep import aabb_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] lo  [AXES],
  input  logic signed [W-1:0] hi  [AXES],
  input  logic signed [W-1:0] org [AXES],
  input  logic signed [W-1:0] dir [AXES],
  output logic                out_valid,
  output aabb_flags_t         out_flags,
  output logic [W-2:0]        rem [LANES],
  output logic [W-1:0]        dvd [LANES],
  output logic [W-1:0]        ad  [LANES],
  output logic                neg [LANES],
  output logic                ovf [LANES]
);

  localparam int NW = W + FRAC_BITS + 1;
  localparam int OW = (NW > 2 * W) ? NW : 2 * W;

  logic signed [W:0]   num_next [LANES];
  logic [W-1:0]        ad_next  [AXES];
  logic [AXES-1:0]     ds_next, dz_next, pass_next;

  logic signed [W:0]   num [LANES];
  logic [W-1:0]        adr [AXES];
  logic [AXES-1:0]     ds, dz, pass;

  logic [W:0]          an [LANES];
  logic [NW-1:0]       nn [LANES];
  logic [NW-1:0]       nsh [LANES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      num_next[2*a]   = $signed({lo[a][W-1], lo[a]}) - $signed({org[a][W-1], org[a]});
      num_next[2*a+1] = $signed({hi[a][W-1], hi[a]}) - $signed({org[a][W-1], org[a]});
      ad_next[a]      = dir[a][W-1] ? W'(-dir[a]) : W'(dir[a]);
      ds_next[a]      = dir[a][W-1];
      dz_next[a]      = (dir[a] == '0);
      pass_next[a]    = (lo[a] <= org[a]) && (org[a] <= hi[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num  <= num_next;
      adr  <= ad_next;
      ds   <= ds_next;
      dz   <= dz_next;
      pass <= pass_next;
    end
  end

  always_comb begin
    out_flags.dz = dz;
    out_flags.ok = &(~dz | pass);
    for (int l = 0; l < LANES; l++) begin
      an[l]  = num[l][W] ? (W+1)'(-num[l]) : (W+1)'(num[l]);
      nn[l]  = {an[l], {FRAC_BITS{1'b0}}};
      nsh[l] = nn[l] >> W;
      rem[l] = nsh[l][W-2:0];
      dvd[l] = nn[l][W-1:0];
      ad[l]  = adr[l >> 1];
      neg[l] = num[l][W] ^ ds[l >> 1];
      ovf[l] = OW'(nn[l]) >= (OW'(adr[l >> 1]) << W);
    end
  end

endmodule

/* src/aabb_div.sv */
module aabb_div import aabb_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  aabb_flags_t         in_flags,
  input  logic [W-2:0]        in_rem [LANES],
  input  logic [W-1:0]        in_dvd [LANES],
  input  logic [W-1:0]        in_ad  [LANES],
  input  logic                in_neg [LANES],
  input  logic                in_ovf [LANES],
  output logic                out_valid,
  output aabb_flags_t         out_flags,
  output logic signed [W-1:0] out_t  [LANES]
);

  localparam logic [W-1:0] TMAX = {1'b0, {(W-1){1'b1}}};

  logic [W-2:0] rem_r [0:W][LANES];
  logic [W-1:0] dvd_r [0:W][LANES];
  logic [W-1:0] ad_r  [0:W][LANES];
  logic [W-1:0] q_r   [0:W][LANES];
  logic         neg_r [0:W][LANES];
  logic         ovf_r [0:W][LANES];
  aabb_flags_t  flags_r [0:W];
  logic         valid_r [0:W];

  logic [W-2:0] rem_next [0:W-1][LANES];
  logic [W-1:0] q_next   [0:W-1][LANES];
  logic [W-1:0] trial    [0:W-1][LANES];
  logic [W-1:0] diff     [0:W-1][LANES];
  logic         ge       [0:W-1][LANES];

  logic [W-1:0]        mag    [LANES];
  logic signed [W-1:0] t_next [LANES];

  always_comb begin
    for (int s = 0; s < W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[s][l]    = {rem_r[s][l], dvd_r[s][l][W-1]};
        ge[s][l]       = trial[s][l] >= ad_r[s][l];
        diff[s][l]     = trial[s][l] - ad_r[s][l];
        rem_next[s][l] = ge[s][l] ? diff[s][l][W-2:0] : trial[s][l][W-2:0];
        q_next[s][l]   = {q_r[s][l][W-2:0], ge[s][l]};
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l]    = (ovf_r[W][l] || q_r[W][l][W-1]) ? TMAX : q_r[W][l];
      t_next[l] = neg_r[W][l] ? $signed(-mag[l]) : $signed(mag[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= W; s++) begin
        valid_r[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int s = 0; s < W; s++) begin
        valid_r[s+1] <= valid_r[s];
      end
      out_valid <= valid_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r[0] <= in_flags;
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= in_rem[l];
        dvd_r[0][l] <= in_dvd[l];
        ad_r[0][l]  <= in_ad[l];
        q_r[0][l]   <= '0;
        neg_r[0][l] <= in_neg[l];
        ovf_r[0][l] <= in_ovf[l];
      end
      for (int s = 0; s < W; s++) begin
        flags_r[s+1] <= flags_r[s];
        for (int l = 0; l < LANES; l++) begin
          rem_r[s+1][l] <= rem_next[s][l];
          dvd_r[s+1][l] <= dvd_r[s][l] << 1;
          ad_r[s+1][l]  <= ad_r[s][l];
          q_r[s+1][l]   <= q_next[s][l];
          neg_r[s+1][l] <= neg_r[s][l];
          ovf_r[s+1][l] <= ovf_r[s][l];
        end
      end
      out_flags <= flags_r[W];
      out_t     <= t_next;
    end
  end

endmodule

/* src/aabb_merge.sv */
module aabb_merge import aabb_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  aabb_flags_t         in_flags,
  input  logic signed [W-1:0] t [LANES],
  input  logic [1:0]          kind,
  output logic                out_valid,
  output logic                hit
);

  localparam int CMPW = (W + 1 > FRAC_BITS + 2) ? W + 1 : FRAC_BITS + 2;
  localparam logic signed [W:0] NEG_INF = {2'b11, {(W-1){1'b0}}};
  localparam logic signed [W:0] POS_INF = {2'b01, {(W-1){1'b0}}};
  localparam logic signed [CMPW-1:0] T_ONE = CMPW'(1) << FRAC_BITS;

  logic signed [W:0] near_next [AXES];
  logic signed [W:0] far_next  [AXES];
  logic signed [W:0] near_r    [AXES];
  logic signed [W:0] far_r     [AXES];
  logic              ok1, v1;

  logic signed [W:0] tmin_next, tmax_next, tmin_r, tmax_r;
  logic              ok2, v2;

  logic signed [CMPW-1:0] tmin_x;
  logic                   hit_next;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (in_flags.dz[a]) begin
        near_next[a] = NEG_INF;
        far_next[a]  = POS_INF;
      end else if (t[2*a] < t[2*a+1]) begin
        near_next[a] = (W+1)'(t[2*a]);
        far_next[a]  = (W+1)'(t[2*a+1]);
      end else begin
        near_next[a] = (W+1)'(t[2*a+1]);
        far_next[a]  = (W+1)'(t[2*a]);
      end
    end
  end

  always_comb begin
    tmin_next = near_r[0];
    tmax_next = far_r[0];
    for (int a = 1; a < AXES; a++) begin
      if (near_r[a] > tmin_next) begin
        tmin_next = near_r[a];
      end
      if (far_r[a] < tmax_next) begin
        tmax_next = far_r[a];
      end
    end
  end

  always_comb begin
    tmin_x   = CMPW'(tmin_r);
    hit_next = ok2 && (tmin_r <= tmax_r);
    case (kind)
      KIND_SEGMENT: hit_next = hit_next && (tmax_r >= 0) && (tmin_x <= T_ONE);
      KIND_RAY:     hit_next = hit_next && (tmax_r >= 0);
      default:      hit_next = hit_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= near_next;
      far_r  <= far_next;
      ok1    <= in_flags.ok;
      tmin_r <= tmin_next;
      tmax_r <= tmax_next;
      ok2    <= ok1;
      hit    <= hit_next;
    end
  end

endmodule

/* src/aabb_ray_slab_test.sv */
// Ray, line and segment test against an axis-aligned box by the slab method. One word is
// taken per cycle and one hit word comes out per word taken, in order; the entry and exit
// parameters are formed by six bit-per-stage dividers. The whole pipeline holds while the
// output word waits, and the user must write query_kind only while no word is in flight;
// the block itself does not enforce this.
module aabb_ray_slab_test import aabb_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic [NUM_FIELDS*FIELD_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hit, then seven zero bits
  output logic [7:0]                      m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_data
);

  localparam int W = COORD_WIDTH;

  logic                en;
  logic [1:0]          kind;
  logic signed [W-1:0] coord [NUM_FIELDS];
  logic signed [W-1:0] lo [AXES], hi [AXES], org [AXES], dir [AXES];

  aabb_flags_t         p_flags, d_flags;
  logic                p_valid, d_valid, hit;
  logic [W-2:0]        p_rem [LANES];
  logic [W-1:0]        p_dvd [LANES];
  logic [W-1:0]        p_ad  [LANES];
  logic                p_neg [LANES];
  logic                p_ovf [LANES];
  logic signed [W-1:0] d_t   [LANES];

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'b0, hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_SEGMENT;
    end else if (cfg_valid) begin
      kind <= cfg_data;
    end
  end

  for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_field
    if (W <= FIELD_W) begin : g_narrow
      assign coord[f] = s_tdata[f*FIELD_W +: W];
    end else begin : g_wide
      assign coord[f] = {{(W-FIELD_W){1'b0}}, s_tdata[f*FIELD_W +: FIELD_W]};
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    assign lo[a]  = coord[a];
    assign hi[a]  = coord[AXES + a];
    assign org[a] = coord[2*AXES + a];
    assign dir[a] = coord[3*AXES + a];
  end

  aabb_prep #(.W(W)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .lo        (lo),
    .hi        (hi),
    .org       (org),
    .dir       (dir),
    .out_valid (p_valid),
    .out_flags (p_flags),
    .rem       (p_rem),
    .dvd       (p_dvd),
    .ad        (p_ad),
    .neg       (p_neg),
    .ovf       (p_ovf)
  );

  aabb_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .in_flags  (p_flags),
    .in_rem    (p_rem),
    .in_dvd    (p_dvd),
    .in_ad     (p_ad),
    .in_neg    (p_neg),
    .in_ovf    (p_ovf),
    .out_valid (d_valid),
    .out_flags (d_flags),
    .out_t     (d_t)
  );

  aabb_merge #(.W(W)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_flags  (d_flags),
    .t         (d_t),
    .kind      (kind),
    .out_valid (m_tvalid),
    .hit       (hit)
  );

endmodule

/* src/aabb_chk.sv */
`include "aabb_ray_slab_test_assert.svh"

module aabb_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  `AABB_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")
  `AABB_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled word changed")
  `AABB_ASSERT(a_in_ready, s_tready == (!m_tvalid || m_tready), "input ready mismatch")
  `AABB_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[7:1] == 7'b0, "pad bits not zero")
  `AABB_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind aabb_ray_slab_test aabb_chk u_chk (.*);
